@@ rtl/core/tpac_pkg.sv @@
// ----------------------------------------------------------------------------
// tpac_pkg
// Types and codes shared by the two-point accelerometer calibration block.
// ----------------------------------------------------------------------------
package tpac_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ACC_W    = 18;
	localparam int NUM_W    = SAMPLE_W + 2;
	localparam int SPAN_W   = SAMPLE_W + 1;
	localparam int LEVELS   = 3;

	localparam logic [1:0] KIND_MEASURE = 2'd0;
	localparam logic [1:0] KIND_PLUS    = 2'd1;
	localparam logic [1:0] KIND_MINUS   = 2'd2;

	localparam logic [1:0] AXIS_LAST = 2'd2;

	localparam logic [1:0] VALID_PLUS  = 2'b01;
	localparam logic [1:0] VALID_MINUS = 2'b10;
	localparam logic [1:0] VALID_BOTH  = 2'b11;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_UNCAL    = 3'd1;
	localparam logic [2:0] STAT_ZERO     = 3'd2;
	localparam logic [2:0] STAT_SAMPLE   = 3'd3;
	localparam logic [2:0] STAT_CAPTURED = 3'd4;

	localparam logic signed [ACC_W-1:0] ACC_MAX = 18'sd131071;
	localparam logic [ACC_W-1:0]        ACC_MIN_MAG = 18'h20000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]                 kind;
		logic [1:0]                 axis;
		logic signed [SAMPLE_W-1:0] sample;
	} in_word_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] accel_fixed;
		logic [1:0]              result_axis;
		logic [2:0]              status;
		logic                    saturated;
	} out_word_t;

endpackage

@@ rtl/core/two_point_accel_calibration.sv @@
// ----------------------------------------------------------------------------
// two_point_accel_calibration
// Per-axis two-point accelerometer calibration: averages plus and minus 1g
// runs into stored levels and corrects measure words to Q.FRAC_BITS in g.
// A corrected measure or a level capture passes through the shared divider,
// which yields one quotient bit per cycle; other words skip the divider. One
// word is in work at a time; the next word is accepted while a finished
// result still waits in the output register.
// Reset clears the calibration run, all stored levels and their valid flags.
// ----------------------------------------------------------------------------
module two_point_accel_calibration
	import tpac_pkg::*;
#(
	parameter int SAMPLES   = 64,
	parameter int FRAC_BITS = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_word_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_word_t result
);

	localparam int SUM_W  = SAMPLE_W + 1 + $clog2(SAMPLES);
	localparam int CNT_W  = $clog2(SAMPLES + 1);
	localparam int MEAS_W = SPAN_W + FRAC_BITS;
	localparam int DVD_W  = (SUM_W > MEAS_W) ? SUM_W : MEAS_W;
	localparam int DVS_W  = (SPAN_W > CNT_W) ? SPAN_W : CNT_W;

	state_t state_q, state_d;

	in_word_t                in_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [1:0]              run_kind_q;
	logic [1:0]              run_axis_q;

	logic signed [SAMPLE_W-1:0] plus_q  [LEVELS];
	logic signed [SAMPLE_W-1:0] minus_q [LEVELS];
	logic [1:0]                 valid_q [LEVELS];

	logic [2:0] status_q;
	logic       use_div_q;
	logic       cal_q;
	logic       neg_q;

	out_word_t out_q;
	logic      out_valid_q;

	logic             is_cal;
	logic             axis_ok;
	logic [1:0]       idx;
	logic             restart;
	logic signed [SUM_W-1:0] sum_new;
	logic [CNT_W-1:0] cnt_new;
	logic             capture;
	logic [SUM_W-1:0] sum_mag;

	logic signed [NUM_W-1:0]  num;
	logic signed [SPAN_W-1:0] span;
	logic [SPAN_W-1:0]        num_mag;
	logic [SPAN_W-1:0]        span_mag;

	logic             div_start;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic             div_done;
	logic [DVD_W-1:0] quo;

	logic       use_div_d;
	logic       neg_d;
	logic [2:0] status_d;
	logic       load_out;
	out_word_t  res_d;
	logic signed [SAMPLE_W-1:0] lvl_d;

	assign is_cal  = (in_q.kind == KIND_PLUS) || (in_q.kind == KIND_MINUS);
	assign axis_ok = in_q.axis <= AXIS_LAST;
	assign idx     = axis_ok ? in_q.axis : 2'd0;

	assign restart = (run_kind_q != in_q.kind) || (run_axis_q != in_q.axis);
	assign sum_new = (restart ? SUM_W'(0) : sum_q)
		+ {{(SUM_W - SAMPLE_W){in_q.sample[SAMPLE_W-1]}}, in_q.sample};
	assign cnt_new = (restart ? CNT_W'(0) : cnt_q) + 1'b1;
	assign capture = cnt_new >= CNT_W'(SAMPLES);
	assign sum_mag = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

	assign num = {in_q.sample[SAMPLE_W-1], in_q.sample, 1'b0}
		- {{2{plus_q[idx][SAMPLE_W-1]}}, plus_q[idx]}
		- {{2{minus_q[idx][SAMPLE_W-1]}}, minus_q[idx]};
	assign span = {plus_q[idx][SAMPLE_W-1], plus_q[idx]}
		- {minus_q[idx][SAMPLE_W-1], minus_q[idx]};
	assign num_mag  = num[NUM_W-1] ? SPAN_W'(-num) : SPAN_W'(num);
	assign span_mag = span[SPAN_W-1] ? SPAN_W'(-span) : SPAN_W'(span);

	always_comb begin
		use_div_d = 1'b0;
		neg_d     = 1'b0;
		status_d  = STAT_UNCAL;
		div_dvd   = DVD_W'(num_mag) << FRAC_BITS;
		div_dvs   = DVS_W'(span_mag);
		if (is_cal) begin
			if (axis_ok) begin
				if (capture) begin
					use_div_d = 1'b1;
					neg_d     = sum_new[SUM_W-1];
					div_dvd   = DVD_W'(sum_mag) + DVD_W'(SAMPLES / 2);
					div_dvs   = DVS_W'(SAMPLES);
				end else begin
					status_d = STAT_SAMPLE;
				end
			end
		end else if (axis_ok && valid_q[idx] == VALID_BOTH) begin
			if (span == '0) begin
				status_d = STAT_ZERO;
			end else begin
				use_div_d = 1'b1;
				neg_d     = num[NUM_W-1] ^ span[SPAN_W-1];
			end
		end
	end

	always_comb begin
		res_d             = '0;
		res_d.result_axis = in_q.axis;
		res_d.status      = status_q;
		lvl_d             = neg_q ? -SAMPLE_W'(quo) : SAMPLE_W'(quo);
		if (use_div_q) begin
			if (cal_q) begin
				res_d.status = STAT_CAPTURED;
			end else begin
				res_d.status = STAT_OK;
				if (neg_q) begin
					if (quo > DVD_W'(ACC_MIN_MAG)) begin
						res_d.accel_fixed = ACC_MIN_MAG;
						res_d.saturated   = 1'b1;
					end else begin
						res_d.accel_fixed = -ACC_W'(quo);
					end
				end else begin
					if (quo > DVD_W'(ACC_MAX)) begin
						res_d.accel_fixed = ACC_MAX;
						res_d.saturated   = 1'b1;
					end else begin
						res_d.accel_fixed = ACC_W'(quo);
					end
				end
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		div_start  = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (use_div_d) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			run_kind_q  <= KIND_MEASURE;
			run_axis_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				plus_q[i]  <= '0;
				minus_q[i] <= '0;
				valid_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_EXEC && is_cal && axis_ok) begin
				if (capture) begin
					sum_q      <= '0;
					cnt_q      <= '0;
					run_kind_q <= KIND_MEASURE;
					run_axis_q <= '0;
				end else begin
					sum_q      <= sum_new;
					cnt_q      <= cnt_new;
					run_kind_q <= in_q.kind;
					run_axis_q <= in_q.axis;
				end
			end
			if (load_out && use_div_q && cal_q) begin
				if (in_q.kind == KIND_PLUS) begin
					plus_q[idx]  <= lvl_d;
					valid_q[idx] <= valid_q[idx] | VALID_PLUS;
				end else begin
					minus_q[idx] <= lvl_d;
					valid_q[idx] <= valid_q[idx] | VALID_MINUS;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			in_q <= item;
		end
		if (state_q == ST_EXEC) begin
			status_q  <= status_d;
			use_div_q <= use_div_d;
			cal_q     <= is_cal;
			neg_q     <= neg_d;
		end
		if (load_out) begin
			out_q <= res_d;
		end
	end

	tpac_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (quo)
	);

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ rtl/core/tpac_div.sv @@
// ----------------------------------------------------------------------------
// tpac_div
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpac_div #(
	parameter int DVD_W = 30,
	parameter int DVS_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] dq_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

@@ tb/two_point_accel_calibration_tb.sv @@
// ----------------------------------------------------------------------------
// two_point_accel_calibration_tb
// Self-checking bench for the two-point accelerometer calibration block.
// Words are sent over the valid/ready input channel with random gaps while the
// output channel stalls at random. Every accepted input word is run through a
// local model of the level averaging and the fixed-point correction, and each
// output word is compared with the oldest predicted word. Directed runs cover
// the uncalibrated, extreme, zero-span, clamping, restart and rounding cases.
// Random runs of calibration and measure words follow.
// ----------------------------------------------------------------------------
module two_point_accel_calibration_tb;
	import tpac_pkg::*;

	localparam int RUN_LEN     = 64;
	localparam int FRAC        = 12;
	localparam int WORD_TARGET = 1650;
	localparam int DRAIN_CYCLES = 80;
	localparam longint Q_MAX   = 131071;
	localparam longint Q_MIN   = -131072;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] AXIS_NONE  = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_word_t  item;
	logic      result_valid;
	logic      result_ready;
	out_word_t result;

	// Local copy of the calibration state.
	longint     cal_sum;
	int         cal_count;
	logic [1:0] cal_axis;
	logic [1:0] cal_kind;
	longint     plus_lvl [LEVELS];
	longint     minus_lvl [LEVELS];
	logic [1:0] lvl_flags [LEVELS];

	out_word_t awaited_words [$];
	int        errors;
	int        words_sent;
	int        words_checked;
	int        n_corrected;
	int        n_clamped;
	int        n_captured;
	bit        no_gaps;

	two_point_accel_calibration #(
		.SAMPLES  (RUN_LEN),
		.FRAC_BITS(FRAC)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #2 clk = ~clk;

	function automatic out_word_t calibrate_step(in_word_t w);
		out_word_t r;
		longint    s;
		longint    lvl;
		longint    span;
		longint    num;
		longint    q;
		r = '0;
		r.result_axis = w.axis;
		s = w.sample;
		if (w.kind == KIND_PLUS || w.kind == KIND_MINUS) begin
			if (w.axis > AXIS_LAST) begin
				r.status = STAT_UNCAL;
			end else begin
				if (cal_kind != w.kind || cal_axis != w.axis) begin
					cal_sum   = 0;
					cal_count = 0;
					cal_kind  = w.kind;
					cal_axis  = w.axis;
				end
				cal_sum += s;
				cal_count++;
				if (cal_count >= RUN_LEN) begin
					if (cal_sum > 0)
						lvl = (cal_sum + RUN_LEN / 2) / RUN_LEN;
					else
						lvl = (cal_sum - RUN_LEN / 2) / RUN_LEN;
					if (w.kind == KIND_PLUS) begin
						plus_lvl[w.axis]  = lvl;
						lvl_flags[w.axis] = lvl_flags[w.axis] | VALID_PLUS;
					end else begin
						minus_lvl[w.axis] = lvl;
						lvl_flags[w.axis] = lvl_flags[w.axis] | VALID_MINUS;
					end
					cal_sum   = 0;
					cal_count = 0;
					cal_axis  = 2'd0;
					cal_kind  = KIND_MEASURE;
					r.status  = STAT_CAPTURED;
				end else begin
					r.status = STAT_SAMPLE;
				end
			end
		end else if (w.axis > AXIS_LAST) begin
			r.status = STAT_UNCAL;
		end else if (lvl_flags[w.axis] != VALID_BOTH) begin
			r.status = STAT_UNCAL;
		end else begin
			span = plus_lvl[w.axis] - minus_lvl[w.axis];
			if (span == 0) begin
				r.status = STAT_ZERO;
			end else begin
				num = 2 * s - plus_lvl[w.axis] - minus_lvl[w.axis];
				q = (num * (longint'(1) << FRAC)) / span;
				if (q > Q_MAX) begin
					q = Q_MAX;
					r.saturated = 1'b1;
				end else if (q < Q_MIN) begin
					q = Q_MIN;
					r.saturated = 1'b1;
				end
				r.accel_fixed = q[ACC_W-1:0];
				r.status = STAT_OK;
			end
		end
		return r;
	endfunction

	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 1;
		else if (r < 90)
			return $urandom_range(2, 4);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input logic [1:0] kind, input logic [1:0] axis,
		input logic signed [SAMPLE_W-1:0] sample);
		int       gap;
		in_word_t w;
		gap = 0;
		if (!no_gaps && $urandom_range(0, 99) >= 55)
			gap = stall_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.kind   = kind;
		w.axis   = axis;
		w.sample = sample;
		item       <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		awaited_words.push_back(calibrate_step(w));
		words_sent++;
	endtask

	// Sends count calibration words around base; mix is the percentage chance
	// of a measure word on a random axis ahead of each calibration word.
	task automatic run_level(input logic [1:0] kind, input logic [1:0] axis,
		input int base, input int spread, input int count, input int mix);
		int v;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < mix)
				send_word(KIND_MEASURE, 2'($urandom_range(0, 2)), 16'($urandom));
			v = base + int'($urandom_range(0, 2 * spread)) - spread;
			if (v > 32767)
				v = 32767;
			else if (v < -32768)
				v = -32768;
			send_word(kind, axis, 16'(v));
		end
	endtask

	task automatic test_uncalibrated();
		for (int a = 0; a < 4; a++) begin
			send_word(KIND_MEASURE, 2'(a), 16'sh7fff);
			send_word(KIND_MEASURE, 2'(a), 16'sh8000);
		end
		send_word(KIND_SPARE, 2'd0, 16'sh0000);
		send_word(KIND_SPARE, AXIS_NONE, 16'shffff);
		send_word(KIND_PLUS, AXIS_NONE, 16'sh7fff);
		send_word(KIND_MINUS, AXIS_NONE, 16'sh8000);
	endtask

	task automatic test_extreme_levels();
		run_level(KIND_PLUS, 2'd0, 32767, 0, RUN_LEN, 0);
		run_level(KIND_MINUS, 2'd0, -32768, 0, RUN_LEN, 0);
		send_word(KIND_MEASURE, 2'd0, 16'sh7fff);
		send_word(KIND_MEASURE, 2'd0, 16'sh8000);
		send_word(KIND_MEASURE, 2'd0, 16'sh0000);
		send_word(KIND_MEASURE, 2'd0, 16'sh0001);
		send_word(KIND_SPARE, 2'd0, 16'shffff);
	endtask

	task automatic test_zero_span();
		run_level(KIND_PLUS, 2'd1, 500, 0, RUN_LEN, 0);
		run_level(KIND_MINUS, 2'd1, 500, 0, RUN_LEN, 0);
		send_word(KIND_MEASURE, 2'd1, 16'sh01f4);
		send_word(KIND_MEASURE, 2'd1, 16'sh8000);
	endtask

	task automatic test_saturation();
		run_level(KIND_PLUS, 2'd2, 1, 0, RUN_LEN, 0);
		run_level(KIND_MINUS, 2'd2, 0, 0, RUN_LEN, 0);
		send_word(KIND_MEASURE, 2'd2, 16'sh7fff);
		send_word(KIND_MEASURE, 2'd2, 16'sh8000);
		send_word(KIND_MEASURE, 2'd2, 16'sh0000);
		// Swapped levels give a negative span.
		run_level(KIND_PLUS, 2'd2, -8000, 0, RUN_LEN, 0);
		run_level(KIND_MINUS, 2'd2, 8000, 0, RUN_LEN, 0);
		send_word(KIND_MEASURE, 2'd2, 16'sh2ee0);
		send_word(KIND_MEASURE, 2'd2, 16'sh8000);
	endtask

	task automatic test_run_restart();
		run_level(KIND_PLUS, 2'd0, 20000, 30, 40, 0);
		run_level(KIND_PLUS, 2'd1, 20000, 30, 10, 0);
		run_level(KIND_MINUS, 2'd0, -20000, 30, RUN_LEN, 10);
		send_word(KIND_MEASURE, 2'd0, 16'sh1000);
		// A lone +32 or -32 in a zero run sits exactly on the rounding half.
		send_word(KIND_PLUS, 2'd1, 16'sh0020);
		run_level(KIND_PLUS, 2'd1, 0, 0, RUN_LEN - 1, 0);
		send_word(KIND_MINUS, 2'd1, -16'sh0020);
		run_level(KIND_MINUS, 2'd1, 0, 0, RUN_LEN - 1, 0);
		send_word(KIND_MEASURE, 2'd1, 16'sh0000);
		send_word(KIND_MEASURE, 2'd1, 16'sh0001);
	endtask

	task automatic test_random();
		int         r;
		int         base;
		logic [1:0] kind;
		while (words_sent < WORD_TARGET) begin
			no_gaps = ($urandom_range(0, 99) < 20);
			r = $urandom_range(0, 99);
			kind = ($urandom_range(0, 1) == 0) ? KIND_PLUS : KIND_MINUS;
			if ($urandom_range(0, 99) < 70)
				base = $urandom_range(1000, 16000);
			else
				base = int'($urandom_range(0, 65535)) - 32768;
			if (kind == KIND_MINUS)
				base = -base;
			if (r < 55) begin
				run_level(kind, 2'($urandom_range(0, 2)), base,
					($urandom_range(0, 9) == 0) ? 2000 : $urandom_range(0, 64), RUN_LEN,
					$urandom_range(0, 15));
			end else if (r < 80) begin
				repeat ($urandom_range(1, 8))
					send_word(KIND_MEASURE,
						($urandom_range(0, 19) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2)),
						16'($urandom));
			end else if (r < 90) begin
				run_level(kind, 2'($urandom_range(0, 2)), base, 200,
					$urandom_range(1, RUN_LEN - 1), 10);
			end else begin
				repeat ($urandom_range(1, 4))
					send_word(2'($urandom), 2'($urandom), 16'($urandom));
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin : result_sink
		result_ready = 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 99) < 15) begin
				result_ready <= 1'b1;
				repeat ($urandom_range(50, 200)) @(posedge clk);
			end else begin
				result_ready <= 1'b0;
				repeat (stall_len()) @(posedge clk);
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		out_word_t want;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: accel %0d axis %0d status %0d sat %0d",
					$time, result.accel_fixed, result.result_axis, result.status,
					result.saturated);
			end else begin
				want = awaited_words.pop_front();
				words_checked++;
				if (want.status == STAT_OK)
					n_corrected++;
				if (want.saturated)
					n_clamped++;
				if (want.status == STAT_CAPTURED)
					n_captured++;
				if (result !== want) begin
					errors++;
					$display({"%0t: mismatch: expected accel %0d axis %0d status %0d",
						" sat %0d, actual accel %0d axis %0d status %0d sat %0d"},
						$time, want.accel_fixed, want.result_axis, want.status,
						want.saturated, result.accel_fixed, result.result_axis,
						result.status, result.saturated);
				end
			end
		end
	end

	initial begin : timeout
		#4000000;
		$display("two_point_accel_calibration test failed");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		errors     = 0;
		words_sent = 0;
		words_checked = 0;
		n_corrected = 0;
		n_clamped  = 0;
		n_captured = 0;
		no_gaps    = 1'b0;
		cal_sum    = 0;
		cal_count  = 0;
		cal_axis   = 2'd0;
		cal_kind   = KIND_MEASURE;
		for (int a = 0; a < LEVELS; a++) begin
			plus_lvl[a]  = 0;
			minus_lvl[a] = 0;
			lvl_flags[a] = 2'b00;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_uncalibrated();
		test_extreme_levels();
		test_zero_span();
		test_saturation();
		test_run_restart();
		test_random();

		item_valid <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words and checked %0d results.", words_sent, words_checked);
		$display("Results: %0d corrected (%0d clamped), %0d levels captured.",
			n_corrected, n_clamped, n_captured);
		if (errors == 0) begin
			$display("two_point_accel_calibration test passed");
		end else begin
			$display("two_point_accel_calibration test failed");
		end
		$finish;
	end

endmodule
